FILE: hw/rtl/wtok_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Word tokenizer package
// Shared transaction types, hash constants and the stop-word table.
// ----------------------------------------------------------------------------
package wtok_pkg;

  localparam logic [31:0] FNV_BASIS       = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME       = 32'd16777619;
  localparam logic [15:0] TOKEN_CAP_RESET = 16'd384;
  localparam logic [15:0] SAT_MAX         = 16'hFFFF;

  localparam int STOP_COUNT  = 52;
  localparam int STOP_MAXLEN = 5;
  localparam int KEY_W       = 8 * STOP_MAXLEN;

  // Input transaction.
  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_byte;
  } in_item_t;

  // Result transaction.
  typedef struct packed {
    logic        token_valid;
    logic [31:0] word_hash;
    logic [15:0] word_start;
    logic [15:0] word_length;
    logic        is_content;
    logic        end_of_text;
  } out_item_t;

  // A byte after classification by the front end.
  typedef struct packed {
    logic [7:0] folded;
    logic       is_word;
    logic       last;
  } cls_item_t;

  // Stop words, right-justified with zero padding above the first letter.
  localparam logic [KEY_W-1:0] STOP_WORDS [STOP_COUNT] = '{
    40'("a"),     40'("an"),    40'("and"),   40'("are"),   40'("as"),
    40'("at"),    40'("be"),    40'("been"),  40'("being"), 40'("by"),
    40'("can"),   40'("could"), 40'("did"),   40'("do"),    40'("does"),
    40'("for"),   40'("from"),  40'("had"),   40'("has"),   40'("have"),
    40'("how"),   40'("i"),     40'("if"),    40'("in"),    40'("is"),
    40'("it"),    40'("its"),   40'("may"),   40'("might"), 40'("of"),
    40'("on"),    40'("or"),    40'("our"),   40'("that"),  40'("the"),
    40'("their"), 40'("this"),  40'("to"),    40'("was"),   40'("we"),
    40'("were"),  40'("what"),  40'("when"),  40'("where"), 40'("which"),
    40'("who"),   40'("why"),   40'("will"),  40'("with"),  40'("would"),
    40'("you"),   40'("your")
  };

  // Word bytes are never zero, so an equal key also means an equal length.
  function automatic logic stop_match(input logic [KEY_W-1:0] key);
    logic hit;
    hit = 1'b0;
    for (int e = 0; e < STOP_COUNT; e++) begin
      if (key == STOP_WORDS[e]) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/word_tokenizer_fnv_hash_stopword.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Word tokenizer with FNV-1a hashes and stop-word marking
// Splits a byte stream into words and emits one token per finished word, up to token_cap per text.
// ----------------------------------------------------------------------------
//
//   Channel  Ports                       Transaction
//   -------  --------------------------  ----------------------------------
//   input    push, full, in_data         one text byte with last-byte flag
//   result   pop, empty, out_data        one token and/or end-of-text mark
//   config   cfg_valid, cfg_ready,       new token_cap value (16 bits)
//            cfg_data
//
// One byte per cycle is sustained while the result queue is not full; the
// cycle is set by the hash update, one constant multiply by the FNV prime.
// A byte is held in the classification queue and its result in the result queue.
// Reset is synchronous and active low: token_cap returns to 384, word state clears.
// A stalled consumer fills the result queue, then the classification queue,
// and only then raises full. Configuration writes are always accepted.
//
// The front end folds case and decides word membership before the byte enters
// a short queue. The back end keeps the running hash, start offset, length
// and the first PREFIX_LEN folded bytes of the current word, compares those
// against the stop-word table when a word ends, and pushes each result
// transaction into a second short queue that the consumer drains through pop.
// ----------------------------------------------------------------------------
module word_tokenizer_fnv_hash_stopword #(
  parameter int PREFIX_LEN = 5
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // Byte input.
  input  wire logic                 push,
  output logic                      full,
  input  wire wtok_pkg::in_item_t   in_data,
  // Results.
  output logic                      empty,
  input  wire logic                 pop,
  output wtok_pkg::out_item_t       out_data,
  // Token cap register.
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [15:0]          cfg_data
);

  import wtok_pkg::*;

  logic [15:0] token_cap_r;
  logic        cls_pop, cls_empty;
  cls_item_t   cls_data;
  logic        res_push, res_full;
  out_item_t   res_data;
  logic [$bits(out_item_t)-1:0] res_q_out;

  // The user must write the register only while no text is in flight; the block does not enforce it.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      token_cap_r <= TOKEN_CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      token_cap_r <= cfg_data;
    end
  end

  wtok_front #(
    .QUEUE_DEPTH (2)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .cls_pop   (cls_pop),
    .cls_empty (cls_empty),
    .cls_data  (cls_data)
  );

  wtok_back #(
    .PREFIX_LEN (PREFIX_LEN)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .token_cap (token_cap_r),
    .cls_empty (cls_empty),
    .cls_data  (cls_data),
    .cls_pop   (cls_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_data)
  );

  // Result queue: separates the back end from a stalling consumer.
  wtok_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (2)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .full    (res_full),
    .wr_data (res_data),
    .pop     (pop),
    .empty   (empty),
    .rd_data (res_q_out)
  );

  assign out_data = out_item_t'(res_q_out);

endmodule
`default_nettype wire

FILE: hw/rtl/wtok_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Word tokenizer queue
// Small register-based first-in first-out queue with push/full, pop/empty.
// ----------------------------------------------------------------------------
module wtok_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  output logic                  full,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             pop,
  output logic                  empty,
  output logic      [WIDTH-1:0] rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/wtok_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Word tokenizer front end
// Classifies each byte as word or separator, folds case, and queues it.
// ----------------------------------------------------------------------------
module wtok_front #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  output logic                      full,
  input  wire wtok_pkg::in_item_t   in_data,
  input  wire logic                 cls_pop,
  output logic                      cls_empty,
  output wtok_pkg::cls_item_t       cls_data
);

  import wtok_pkg::*;

  logic [7:0] b;
  logic       is_upper, is_lower, is_digit;
  cls_item_t  cls;
  logic [$bits(cls_item_t)-1:0] q_out;

  assign b        = in_data.text_byte;
  assign is_upper = (b >= 8'("A")) && (b <= 8'("Z"));
  assign is_lower = (b >= 8'("a")) && (b <= 8'("z"));
  assign is_digit = (b >= 8'("0")) && (b <= 8'("9"));

  always_comb begin
    cls.folded  = is_upper ? (b + 8'd32) : b;
    cls.is_word = is_upper || is_lower || is_digit || (b == 8'("_")) ||
                  (b == 8'("-")) || b[7];
    cls.last    = in_data.last_byte;
  end

  wtok_fifo #(
    .WIDTH ($bits(cls_item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_cls_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .wr_data (cls),
    .pop     (cls_pop),
    .empty   (cls_empty),
    .rd_data (q_out)
  );

  assign cls_data = cls_item_t'(q_out);

endmodule
`default_nettype wire

FILE: hw/rtl/wtok_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Word tokenizer back end
// Tracks word state, updates the FNV-1a hash and forms result transactions.
// ----------------------------------------------------------------------------
module wtok_back #(
  parameter int PREFIX_LEN = 5
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [15:0]          token_cap,
  input  wire logic                 cls_empty,
  input  wire wtok_pkg::cls_item_t  cls_data,
  output logic                      cls_pop,
  input  wire logic                 res_full,
  output logic                      res_push,
  output wtok_pkg::out_item_t       res_data
);

  import wtok_pkg::*;

  localparam int PIDX_W = $clog2(PREFIX_LEN);

  logic        inside_r, inside_nxt;
  logic [31:0] hash_r, hash_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic [15:0] start_r, start_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] tok_r, tok_nxt;
  logic [7:0]  prefix_r [PREFIX_LEN];

  logic        fire, w, first_byte, ends, emit;
  logic [15:0] len_base;
  logic [31:0] hash_base, hash_mix;
  logic [7:0]  pbyte [STOP_MAXLEN];
  logic [KEY_W-1:0] key;
  logic        is_stop;

  assign fire       = !cls_empty && !res_full;
  assign cls_pop    = fire;
  assign w          = cls_data.is_word;
  assign first_byte = w && !inside_r;
  assign len_base   = first_byte ? '0 : len_r;
  assign hash_base  = first_byte ? FNV_BASIS : hash_r;
  assign hash_mix   = hash_base ^ {24'd0, cls_data.folded};
  assign ends       = (inside_r || w) && (!w || cls_data.last);
  assign emit       = ends && (tok_r < token_cap);
  assign res_push   = fire && (emit || cls_data.last);

  // Word contents as they stand after this byte, for the stop-word check.
  always_comb begin
    for (int i = 0; i < STOP_MAXLEN; i++) begin
      pbyte[i] = (w && len_base == 16'(i)) ? cls_data.folded : prefix_r[i];
    end
    key = '0;
    for (int i = 0; i < STOP_MAXLEN; i++) begin
      if (16'(i) < len_nxt) begin
        key = {key[KEY_W-9:0], pbyte[i]};
      end
    end
    is_stop = (len_nxt != '0) && (len_nxt <= 16'(STOP_MAXLEN)) && stop_match(key);
  end

  always_comb begin
    start_nxt = first_byte ? pos_r : start_r;
    hash_nxt  = hash_r;
    len_nxt   = len_r;
    if (w) begin
      hash_nxt = 32'(hash_mix * FNV_PRIME);
      len_nxt  = (len_base == SAT_MAX) ? len_base : len_base + 1'b1;
    end
  end

  always_comb begin
    res_data.token_valid = emit;
    res_data.word_hash   = emit ? hash_nxt : '0;
    res_data.word_start  = emit ? start_nxt : '0;
    res_data.word_length = emit ? len_nxt : '0;
    res_data.is_content  = emit && !is_stop;
    res_data.end_of_text = cls_data.last;
  end

  always_comb begin
    inside_nxt = (inside_r || w) && !ends;
    tok_nxt    = (emit && tok_r != SAT_MAX) ? tok_r + 1'b1 : tok_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r <= 1'b0;
      hash_r   <= FNV_BASIS;
      pos_r    <= '0;
      start_r  <= '0;
      len_r    <= '0;
      tok_r    <= '0;
    end else if (fire) begin
      if (cls_data.last) begin
        inside_r <= 1'b0;
        hash_r   <= FNV_BASIS;
        pos_r    <= '0;
        start_r  <= '0;
        len_r    <= '0;
        tok_r    <= '0;
      end else begin
        inside_r <= inside_nxt;
        hash_r   <= hash_nxt;
        pos_r    <= (pos_r == SAT_MAX) ? pos_r : pos_r + 1'b1;
        start_r  <= start_nxt;
        len_r    <= len_nxt;
        tok_r    <= tok_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && w && len_base < 16'(PREFIX_LEN)) begin
      prefix_r[len_base[PIDX_W-1:0]] <= cls_data.folded;
    end
  end

  // A word in progress always holds at least one byte.
  a_inside_len : assert property (@(posedge clk) disable iff (!rst_n)
    inside_r |-> len_r != '0)
    else $error("word in progress with zero length");

  // The last byte of a text leaves the block ready for a fresh text.
  a_text_clear : assert property (@(posedge clk) disable iff (!rst_n)
    fire && cls_data.last |=> !inside_r && tok_r == '0 && pos_r == '0)
    else $error("text state not cleared after last byte");

  // Results never go out without a token unless they close the text.
  a_res_kind : assert property (@(posedge clk) disable iff (!rst_n)
    res_push && !res_data.end_of_text |-> res_data.token_valid)
    else $error("empty result in the middle of a text");

  // A token only leaves with the cap not yet reached.
  a_cap : assert property (@(posedge clk) disable iff (!rst_n)
    res_push && res_data.token_valid |-> tok_r < token_cap)
    else $error("token emitted beyond cap");

endmodule
`default_nettype wire
